// ===== sv/tcw_pkg.sv =====
// shared types and constants of the text console writer
`timescale 1ns / 1ps

package tcw_pkg;

    // fixed field widths
    localparam int CHAR_W      = 8;
    localparam int COLOR_W     = 8;
    localparam int CELL_W      = 16;
    localparam int IDX_W       = 11;
    localparam int POS_OUT_W   = 11;
    localparam int COL_OUT_W   = 7;
    localparam int ROW_OUT_W   = 5;
    localparam int S_TDATA_W   = 24;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 40;

    // input beat layout
    localparam int S_CHAR_LSB  = 0;
    localparam int S_IDX_LSB   = 8;

    // output beat layout
    localparam int M_POS_LSB   = 0;
    localparam int M_COL_LSB   = 11;
    localparam int M_ROW_LSB   = 18;
    localparam int M_SCR_BIT   = 23;
    localparam int M_CELL_LSB  = 24;

    // item kinds carried in tuser
    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // control characters
    localparam logic [CHAR_W-1:0] CODE_DEL = 8'h7f;
    localparam logic [CHAR_W-1:0] CODE_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CODE_CR  = 8'h0d;
    localparam logic [CHAR_W-1:0] CODE_LF  = 8'h0a;

    // store contents
    localparam logic [CELL_W-1:0]  BLANK_CELL       = 16'h0720;
    localparam logic [CELL_W-1:0]  EMPTY_CELL       = 16'h0000;
    localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'h07;

    // cursor operations
    typedef enum logic [1:0] {
        CUR_BACK,
        CUR_NEWLINE,
        CUR_ADVANCE
    } cur_op_t;

    typedef struct packed {
        logic    valid;
        cur_op_t op;
    } cur_cmd_t;

endpackage

// ===== sv/tcw_screen_mem.sv =====
// screen cell store, one write port and one registered read port
`timescale 1ns / 1ps

module tcw_screen_mem #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [tcw_pkg::CELL_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic [tcw_pkg::CELL_W-1:0] rd_data
);

    logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];
    logic [tcw_pkg::CELL_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/tcw_cursor.sv =====
// cursor column and row registers with their step logic
`timescale 1ns / 1ps

module tcw_cursor #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tcw_pkg::cur_cmd_t           cmd,
    output logic [$clog2(COLUMNS)-1:0]  col,
    output logic [$clog2(ROWS)-1:0]     row,
    output logic [$clog2(COLUMNS*ROWS)-1:0] pos,
    output logic                        scroll
);

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(COLUMNS * ROWS);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             row_step;

    // next cursor for the requested step
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        row_step = 1'b0;
        scroll   = 1'b0;
        if (cmd.valid)
        begin
            unique case (cmd.op)
                tcw_pkg::CUR_BACK:
                begin
                    if (col_reg != '0)
                    begin
                        col_next = col_reg - 1'b1;
                    end
                end
                tcw_pkg::CUR_NEWLINE:
                begin
                    col_next = '0;
                    row_step = 1'b1;
                end
                tcw_pkg::CUR_ADVANCE:
                begin
                    if (col_reg == COL_W'(COLUMNS - 1))
                    begin
                        col_next = '0;
                        row_step = 1'b1;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        // stepping onto the last row scrolls, the row itself stays put
        if (row_step)
        begin
            if (row_reg == ROW_W'(ROWS - 2))
            begin
                scroll = 1'b1;
            end
            else
            begin
                row_next = row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // linear cell address of the cursor
    assign pos = ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign col = col_reg;
    assign row = row_reg;

endmodule

// ===== sv/text_console_writer_core.sv =====
// text console writer top level: sequencer, config register and output register
//
//  channel   direction  fields (lsb first)                                   handshake
//  s_*       in         tdata: char_code[7:0] cell_index[18:8]; tuser: kind  tvalid/tready
//  m_*       out        tdata: cursor_pos cursor_column cursor_row scrolled
//                              cell_value                                    tvalid/tready
//  cfg_*     in         cfg_wr_data: text_color                              cfg_wr_en
//
// a read goes from idle to ST_OUT, which registers its result and returns to idle;
// a put goes through ST_PUT and ST_OUT; a put that scrolls passes ST_SCROLL between them,
// one cell moved or cleared per cycle through the single store write port.
// after reset a clearing pass writes every cell once, s_tready low.
// one item is in flight at a time; s_tready is high only while the sequencer is idle.
// a stalled result holds in the output register; the block goes idle once it is loaded.
`timescale 1ns / 1ps

module text_console_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input beats
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tcw_pkg::S_TDATA_W-1:0]  s_tdata,   // char_code, cell_index, zero pad
    input  logic [tcw_pkg::S_TUSER_W-1:0]  s_tuser,   // kind
    // result beats
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tcw_pkg::M_TDATA_W-1:0]  m_tdata,   // cursor_pos, cursor_column, cursor_row,
                                                      // scrolled, cell_value
    // color register
    input  logic                           cfg_wr_en,
    input  logic [tcw_pkg::COLOR_W-1:0]    cfg_wr_data
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int MOVE_COUNT = CELL_COUNT - COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int IDX_WIDE_W = (ADDR_W > tcw_pkg::IDX_W) ? ADDR_W : tcw_pkg::IDX_W;
    localparam int POS_WIDE_W = (ADDR_W > tcw_pkg::POS_OUT_W) ? ADDR_W : tcw_pkg::POS_OUT_W;
    localparam int ROW_WIDE_W = (ROW_W > tcw_pkg::ROW_OUT_W) ? ROW_W : tcw_pkg::ROW_OUT_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PUT,
        ST_SCROLL,
        ST_OUT
    } state_t;

    state_t                         state_reg, state_next;
    logic [ADDR_W-1:0]              cnt_reg, cnt_next;
    logic [tcw_pkg::CHAR_W-1:0]     char_reg, char_next;
    logic                           kind_reg, kind_next;
    logic                           oob_reg, oob_next;
    logic                           scrolled_reg, scrolled_next;
    logic [tcw_pkg::COLOR_W-1:0]    color_reg;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [tcw_pkg::M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    // store port controls
    logic                           wr_en;
    logic [ADDR_W-1:0]              wr_addr;
    logic [tcw_pkg::CELL_W-1:0]     wr_data;
    logic                           rd_en;
    logic [ADDR_W-1:0]              rd_addr;
    logic [tcw_pkg::CELL_W-1:0]     rd_data;

    // cursor unit
    tcw_pkg::cur_cmd_t              cur_cmd;
    logic [COL_W-1:0]               cur_col;
    logic [ROW_W-1:0]               cur_row;
    logic [ADDR_W-1:0]              cur_pos;
    logic                           cur_scroll;

    // decoded input beat
    logic [tcw_pkg::CHAR_W-1:0]     in_char;
    logic [IDX_WIDE_W-1:0]          in_idx;
    logic                           in_oob;
    tcw_pkg::cur_op_t               put_op;
    logic                           put_prints;

    // scroll address unit
    logic [ADDR_W:0]                src_addr;
    logic                           src_live;

    // result packing
    logic [POS_WIDE_W-1:0]          pos_wide;
    logic [ROW_WIDE_W-1:0]          row_wide;
    logic [tcw_pkg::CELL_W-1:0]     cell_out;

    assign in_char = s_tdata[tcw_pkg::S_CHAR_LSB +: tcw_pkg::CHAR_W];
    assign in_idx  = IDX_WIDE_W'(s_tdata[tcw_pkg::S_IDX_LSB +: tcw_pkg::IDX_W]);
    assign in_oob  = in_idx >= IDX_WIDE_W'(CELL_COUNT);

    // character class of the pending put
    always_comb
    begin
        put_prints = 1'b0;
        if (char_reg == tcw_pkg::CODE_DEL || char_reg == tcw_pkg::CODE_BS)
        begin
            put_op = tcw_pkg::CUR_BACK;
        end
        else if (char_reg == tcw_pkg::CODE_CR || char_reg == tcw_pkg::CODE_LF)
        begin
            put_op = tcw_pkg::CUR_NEWLINE;
        end
        else
        begin
            put_op     = tcw_pkg::CUR_ADVANCE;
            put_prints = 1'b1;
        end
    end

    // source of the next row move: one row below the cell after the current one
    assign src_addr = (ADDR_W + 1)'(cnt_reg) + (ADDR_W + 1)'(COLUMNS + 1);
    assign src_live = (ADDR_W + 1)'(cnt_reg) + 1'b1 < (ADDR_W + 1)'(MOVE_COUNT);

    // result fields
    assign pos_wide = POS_WIDE_W'(cur_pos);
    assign row_wide = ROW_WIDE_W'(cur_row);
    assign cell_out = (kind_reg == tcw_pkg::KIND_READ && !oob_reg) ? rd_data
                                                                    : tcw_pkg::EMPTY_CELL;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        char_next     = char_reg;
        kind_next     = kind_reg;
        oob_next      = oob_reg;
        scrolled_next = scrolled_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        wr_en         = 1'b0;
        wr_addr       = cnt_reg;
        wr_data       = tcw_pkg::BLANK_CELL;
        rd_en         = 1'b0;
        rd_addr       = in_idx[ADDR_W-1:0];
        cur_cmd.valid = 1'b0;
        cur_cmd.op    = put_op;
        s_tready      = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // fill the store with blanks
                wr_en = 1'b1;
                if (cnt_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    kind_next     = s_tuser[0];
                    scrolled_next = 1'b0;
                    if (s_tuser[0] == tcw_pkg::KIND_READ)
                    begin
                        rd_en      = !in_oob;
                        oob_next   = in_oob;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        char_next  = in_char;
                        state_next = ST_PUT;
                    end
                end
            end
            ST_PUT:
            begin
                // write a printable character and step the cursor
                cur_cmd.valid = 1'b1;
                wr_en         = put_prints;
                wr_addr       = cur_pos;
                wr_data       = {color_reg, char_reg};
                if (cur_scroll)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = ADDR_W'(COLUMNS);
                    cnt_next      = '0;
                    scrolled_next = 1'b1;
                    state_next    = ST_SCROLL;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_SCROLL:
            begin
                // move one cell up a row per cycle, then clear the last row to empty cells
                wr_en   = 1'b1;
                wr_data = (cnt_reg < ADDR_W'(MOVE_COUNT)) ? rd_data : tcw_pkg::EMPTY_CELL;
                rd_en   = src_live;
                rd_addr = src_addr[ADDR_W-1:0];
                if (cnt_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                // load the result once the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {cell_out,
                                     scrolled_reg,
                                     row_wide[tcw_pkg::ROW_OUT_W-1:0],
                                     tcw_pkg::COL_OUT_W'(cur_col),
                                     pos_wide[tcw_pkg::POS_OUT_W-1:0]};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            char_reg     <= '0;
            kind_reg     <= tcw_pkg::KIND_PUT;
            oob_reg      <= 1'b0;
            scrolled_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            char_reg     <= char_next;
            kind_reg     <= kind_next;
            oob_reg      <= oob_next;
            scrolled_reg <= scrolled_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    // color register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= tcw_pkg::TEXT_COLOR_RESET;
        end
        else if (cfg_wr_en)
        begin
            color_reg <= cfg_wr_data;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    tcw_screen_mem #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tcw_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cur_cmd),
        .col    (cur_col),
        .row    (cur_row),
        .pos    (cur_pos),
        .scroll (cur_scroll)
    );

endmodule

// ===== sv/tcw_checker.sv =====
// port checker for the text console writer and its bind
`timescale 1ns / 1ps

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tcw_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [tcw_pkg::POS_OUT_W-1:0] res_pos;
    logic [tcw_pkg::COL_OUT_W-1:0] res_col;
    logic [tcw_pkg::ROW_OUT_W-1:0] res_row;
    logic                          res_scrolled;
    logic [31:0]                   calc_pos;

    assign res_pos      = m_tdata[tcw_pkg::M_POS_LSB +: tcw_pkg::POS_OUT_W];
    assign res_col      = m_tdata[tcw_pkg::M_COL_LSB +: tcw_pkg::COL_OUT_W];
    assign res_row      = m_tdata[tcw_pkg::M_ROW_LSB +: tcw_pkg::ROW_OUT_W];
    assign res_scrolled = m_tdata[tcw_pkg::M_SCR_BIT];
    assign calc_pos     = 32'(res_row) * 32'(COLUMNS) + 32'(res_col);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

    // one item at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an item is in flight");

    // cursor column stays inside the row
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> 32'(res_col) < 32'(COLUMNS))
    else $error("cursor column out of range");

    // a scroll leaves the cursor on the row above the last
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res_scrolled |-> res_row == tcw_pkg::ROW_OUT_W'(ROWS - 2))
    else $error("scroll left the cursor on the wrong row");

    // linear position agrees with column and row when the row fits the field
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ROWS <= 33 |-> res_pos == calc_pos[tcw_pkg::POS_OUT_W-1:0])
    else $error("cursor position does not match column and row");

endmodule

bind text_console_writer_core tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== verif/tb_text_console_writer_core.sv =====
// testbench for the text console writer: directed table and random beats against a predictor
`timescale 1ns / 1ps

module tb_text_console_writer_core;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int CELL_COUNT   = COLUMNS * ROWS;
    localparam int IDLE_PCT     = 33;
    localparam int STALL_LIMIT  = 20000;
    localparam int PHASE_ITEMS  = 270;
    localparam int NUM_PHASES   = 5;
    localparam int NUM_ROWS     = 23;
    localparam int DRAIN_CYCLES = 20;
    localparam int PAD_W        = tcw_pkg::S_TDATA_W - tcw_pkg::IDX_W - tcw_pkg::CHAR_W;

    // one result beat, fields listed from the msb down
    typedef struct packed {
        logic [tcw_pkg::CELL_W-1:0]    cell_value;
        logic                          scrolled;
        logic [tcw_pkg::ROW_OUT_W-1:0] cursor_row;
        logic [tcw_pkg::COL_OUT_W-1:0] cursor_column;
        logic [tcw_pkg::POS_OUT_W-1:0] cursor_pos;
    } console_result_t;

    // one row of the directed table
    typedef struct {
        logic                       kind;
        logic [tcw_pkg::CHAR_W-1:0] code;
        logic [tcw_pkg::IDX_W-1:0]  cell_idx;
        int                         reps;
        bit                         fixed;
        console_result_t            result;
    } stim_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [tcw_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [tcw_pkg::S_TUSER_W-1:0] s_tuser = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [tcw_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          cfg_wr_en = 1'b0;
    logic [tcw_pkg::COLOR_W-1:0]   cfg_wr_data = '0;

    // predictor state
    logic [tcw_pkg::CELL_W-1:0]    screen_model [CELL_COUNT];
    int unsigned                   model_col;
    int unsigned                   model_row;
    logic [tcw_pkg::COLOR_W-1:0]   model_color;
    console_result_t               pending_results [$];

    bit                            no_idle = 1'b0;
    int                            fail_count = 0;
    int                            quiet_cycles = 0;
    stim_row_t                     directed_rows [NUM_ROWS];
    logic [tcw_pkg::COLOR_W-1:0]   phase_colors [NUM_PHASES];

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    text_console_writer_core #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // shift all rows up once the cursor sits on the last row
    function automatic bit scroll_model();
        int i;
        if (model_row + 1 < ROWS)
            return 1'b0;
        for (i = 0; i + COLUMNS < CELL_COUNT; i++)
            screen_model[i] = screen_model[i + COLUMNS];
        for (i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
            screen_model[i] = tcw_pkg::EMPTY_CELL;
        model_row = ROWS - 2;
        return 1'b1;
    endfunction

    // console behavior for one accepted beat
    function automatic console_result_t predict_console(logic kind,
                                                        logic [tcw_pkg::CHAR_W-1:0] code,
                                                        logic [tcw_pkg::IDX_W-1:0] cell_idx);
        console_result_t r;
        int              pos;
        r = '0;
        if (kind == tcw_pkg::KIND_READ)
        begin
            if (cell_idx < CELL_COUNT)
                r.cell_value = screen_model[cell_idx];
        end
        else
        begin
            r.scrolled = scroll_model();
            if (code == tcw_pkg::CODE_DEL || code == tcw_pkg::CODE_BS)
            begin
                // clamped at the left edge
                if (model_col > 0)
                    model_col--;
            end
            else if (code == tcw_pkg::CODE_CR || code == tcw_pkg::CODE_LF)
            begin
                model_col = 0;
                model_row++;
            end
            else
            begin
                pos = model_row * COLUMNS + model_col;
                if (pos < CELL_COUNT)
                    screen_model[pos] = {model_color, code};
                model_col++;
                if (model_col >= COLUMNS)
                begin
                    model_col = 0;
                    model_row++;
                end
            end
            if (scroll_model())
                r.scrolled = 1'b1;
        end
        r.cursor_pos    = tcw_pkg::POS_OUT_W'(model_row * COLUMNS + model_col);
        r.cursor_column = tcw_pkg::COL_OUT_W'(model_col);
        r.cursor_row    = tcw_pkg::ROW_OUT_W'(model_row);
        return r;
    endfunction

    // drive one input beat, with a random gap ahead of it
    task automatic send_beat(input logic kind, input logic [tcw_pkg::CHAR_W-1:0] code,
                             input logic [tcw_pkg::IDX_W-1:0] cell_idx, input bit fixed,
                             input console_result_t fixed_result);
        console_result_t r;
        if (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < IDLE_PCT)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{PAD_W{1'b0}}, cell_idx, code};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = predict_console(kind, code, cell_idx);
        pending_results.push_back(fixed ? fixed_result : r);
    endtask

    // color write once the block is idle and nothing is outstanding
    task automatic write_color(input logic [tcw_pkg::COLOR_W-1:0] color);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || !s_tready)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= color;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        model_color = color;
    endtask

    // result checker, output stalls and watchdog
    always @(posedge clk)
    begin : result_monitor
        console_result_t got;
        console_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.cursor_pos    = m_tdata[tcw_pkg::M_POS_LSB +: tcw_pkg::POS_OUT_W];
            got.cursor_column = m_tdata[tcw_pkg::M_COL_LSB +: tcw_pkg::COL_OUT_W];
            got.cursor_row    = m_tdata[tcw_pkg::M_ROW_LSB +: tcw_pkg::ROW_OUT_W];
            got.scrolled      = m_tdata[tcw_pkg::M_SCR_BIT];
            got.cell_value    = m_tdata[tcw_pkg::M_CELL_LSB +: tcw_pkg::CELL_W];
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected: %h", got);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.cursor_pos !== want.cursor_pos)
                begin
                    $error("cursor_pos expected %0d actual %0d", want.cursor_pos,
                           got.cursor_pos);
                    fail_count++;
                end
                if (got.cursor_column !== want.cursor_column)
                begin
                    $error("cursor_column expected %0d actual %0d", want.cursor_column,
                           got.cursor_column);
                    fail_count++;
                end
                if (got.cursor_row !== want.cursor_row)
                begin
                    $error("cursor_row expected %0d actual %0d", want.cursor_row,
                           got.cursor_row);
                    fail_count++;
                end
                if (got.scrolled !== want.scrolled)
                begin
                    $error("scrolled expected %0d actual %0d", want.scrolled, got.scrolled);
                    fail_count++;
                end
                if (got.cell_value !== want.cell_value)
                begin
                    $error("cell_value expected %h actual %h", want.cell_value,
                           got.cell_value);
                    fail_count++;
                end
            end
        end
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        // cycles with no beat on either side
        if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int                         i;
        int                         ph;
        int                         n;
        int                         k;
        int                         pick;
        int                         base;
        logic                       kind;
        logic [tcw_pkg::CHAR_W-1:0] code;
        logic [tcw_pkg::IDX_W-1:0]  cell_idx;

        // predictor reset
        for (i = 0; i < CELL_COUNT; i++)
            screen_model[i] = tcw_pkg::BLANK_CELL;
        model_col   = 0;
        model_row   = 0;
        model_color = tcw_pkg::TEXT_COLOR_RESET;

        // kind, code, index, repeat, fixed, expected {cell, scrolled, row, column, pos}
        directed_rows = '{
            // blank store after reset, reads at both ends and past the end
            '{tcw_pkg::KIND_READ, 8'hff, 11'd0,    1, 1'b1,
              '{tcw_pkg::BLANK_CELL, 1'b0, 5'd0, 7'd0, 11'd0}},
            '{tcw_pkg::KIND_READ, 8'h00, 11'd1999, 1, 1'b1,
              '{tcw_pkg::BLANK_CELL, 1'b0, 5'd0, 7'd0, 11'd0}},
            '{tcw_pkg::KIND_READ, 8'h00, 11'd2000, 1, 1'b1,
              '{tcw_pkg::EMPTY_CELL, 1'b0, 5'd0, 7'd0, 11'd0}},
            '{tcw_pkg::KIND_READ, 8'hff, 11'd2047, 1, 1'b1,
              '{tcw_pkg::EMPTY_CELL, 1'b0, 5'd0, 7'd0, 11'd0}},
            // step back at the left edge stays put
            '{tcw_pkg::KIND_PUT, tcw_pkg::CODE_BS,  11'd2047, 1, 1'b1,
              '{tcw_pkg::EMPTY_CELL, 1'b0, 5'd0, 7'd0, 11'd0}},
            '{tcw_pkg::KIND_PUT, tcw_pkg::CODE_DEL, 11'd0,    1, 1'b1,
              '{tcw_pkg::EMPTY_CELL, 1'b0, 5'd0, 7'd0, 11'd0}},
            '{tcw_pkg::KIND_PUT, 8'h41,             11'd0,    1, 1'b1,
              '{tcw_pkg::EMPTY_CELL, 1'b0, 5'd0, 7'd1, 11'd1}},
            // code extremes and a space
            '{tcw_pkg::KIND_PUT,  8'h00,             11'd0,    1, 1'b0, '0},
            '{tcw_pkg::KIND_PUT,  8'hff,             11'd2047, 1, 1'b0, '0},
            '{tcw_pkg::KIND_PUT,  8'h20,             11'd0,    1, 1'b0, '0},
            '{tcw_pkg::KIND_READ, 8'h00,             11'd0,    1, 1'b0, '0},
            '{tcw_pkg::KIND_READ, 8'h00,             11'd2,    1, 1'b0, '0},
            // step back and overwrite
            '{tcw_pkg::KIND_PUT,  tcw_pkg::CODE_BS,  11'd0,    1, 1'b0, '0},
            '{tcw_pkg::KIND_PUT,  tcw_pkg::CODE_DEL, 11'd0,    1, 1'b0, '0},
            '{tcw_pkg::KIND_PUT,  8'h42,             11'd0,    1, 1'b0, '0},
            // new lines down to the row above the last, then a scroll
            '{tcw_pkg::KIND_PUT,  tcw_pkg::CODE_CR,  11'd0,    1, 1'b0, '0},
            '{tcw_pkg::KIND_PUT,  tcw_pkg::CODE_LF,  11'd0,    1, 1'b0, '0},
            '{tcw_pkg::KIND_PUT,  tcw_pkg::CODE_LF,  11'd0,   21, 1'b0, '0},
            '{tcw_pkg::KIND_PUT,  tcw_pkg::CODE_LF,  11'd0,    1, 1'b0, '0},
            '{tcw_pkg::KIND_READ, 8'h00,             11'd1920, 1, 1'b0, '0},
            '{tcw_pkg::KIND_READ, 8'h00,             11'd0,    1, 1'b0, '0},
            '{tcw_pkg::KIND_READ, 8'h00,             11'd1919, 1, 1'b0, '0},
            '{tcw_pkg::KIND_PUT,  8'h7e,             11'd0,    1, 1'b0, '0}
        };

        phase_colors[0] = 8'h00;
        phase_colors[1] = 8'hff;
        phase_colors[2] = tcw_pkg::COLOR_W'($urandom_range(255));
        phase_colors[3] = 8'h1e;
        phase_colors[4] = tcw_pkg::COLOR_W'($urandom_range(255));

        // reset
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;

        // directed table under the reset color
        for (i = 0; i < NUM_ROWS; i++)
            for (k = 0; k < directed_rows[i].reps; k++)
                send_beat(directed_rows[i].kind, directed_rows[i].code,
                          directed_rows[i].cell_idx, directed_rows[i].fixed,
                          directed_rows[i].result);

        // random phases, one color each, one phase without idling
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_color(phase_colors[ph]);
            no_idle <= (ph == 2);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                code     = tcw_pkg::CHAR_W'($urandom_range(255));
                cell_idx = tcw_pkg::IDX_W'($urandom_range(2047));
                if ($urandom_range(99) < 25)
                begin
                    kind = tcw_pkg::KIND_READ;
                    pick = $urandom_range(99);
                    if (pick < 50)
                    begin
                        // near the cursor, where writes just landed
                        base = int'(model_row * COLUMNS + model_col) -
                               int'($urandom_range(160));
                        cell_idx = tcw_pkg::IDX_W'((base < 0) ? 0 : base);
                    end
                    else if (pick < 90)
                        cell_idx = tcw_pkg::IDX_W'($urandom_range(CELL_COUNT - 1));
                    else
                        cell_idx = tcw_pkg::IDX_W'($urandom_range(2047, CELL_COUNT));
                end
                else
                begin
                    kind = tcw_pkg::KIND_PUT;
                    pick = $urandom_range(99);
                    if (pick < 5)
                        code = tcw_pkg::CODE_CR;
                    else if (pick < 10)
                        code = tcw_pkg::CODE_LF;
                    else if (pick < 14)
                        code = tcw_pkg::CODE_BS;
                    else if (pick < 17)
                        code = tcw_pkg::CODE_DEL;
                end
                send_beat(kind, code, cell_idx, 1'b0, '0);
            end
        end

        // drain
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
